// ===== rtl/clint_pkg.sv =====
// Shared definitions for the core-local timer interrupter: address map,
// operation codes, hart limits and the decoded-access struct.
// No dependencies.
`timescale 1ns / 1ps

package clint_pkg;

   // Operation codes carried on the request channel
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Address map
   localparam logic [15:0] COUNTER_OFFSET = 16'hBFF8;
   localparam logic [15:0] COMPARE_BASE   = 16'h4000;
   localparam logic [3:0]  SIZE_DWORD     = 4'd8;
   localparam logic [3:0]  SIZE_WORD      = 4'd4;

   // Hart limits
   localparam int DEFAULT_NUM_HARTS = 4;
   localparam int MAX_HARTS         = 32;
   localparam int HART_IDX_W        = 5;
   localparam int OUT_HARTS         = 4;

   // Decoded access, handed from the decoder to the state logic
   typedef struct packed {
      logic                  ok;
      logic                  is_tick;
      logic                  is_write;
      logic                  sel_counter;
      logic                  sel_compare;
      logic                  sel_soft;
      logic [HART_IDX_W-1:0] hart;
   } decode_type;

endpackage

// ===== rtl/core_local_timer_interrupter_unit.sv =====
// Core-local timer interrupter: 64-bit time counter, per-hart compare
// registers, latched timer pending and software interrupt bits.
// Depends on clint_pkg and clint_decode.
`timescale 1ns / 1ps

// Usage
// - Request channel (req_*): one beat is a bus read, a bus write or a single
//   timer tick. Accepted when req_valid is high and req_stall is low.
// - Response channel (rsp_*): exactly one beat per request, in order, with
//   ok, read data and the timer and software pending bits of harts 0..3 as
//   they stand after that request.
// - Path: a request is captured in the request register when accepted, is
//   processed from there and its response is held in the response
//   register, from which the receiver takes it.
// - Throughput: one request per cycle while the receiver takes responses.
//   The counter increment, the decode and the per-hart 64-bit compares
//   all sit in one stage between the request and response registers.
// - When the receiver stalls, the response register holds; the request
//   register keeps its beat and req_stall rises once it is occupied, so at
//   most two requests are in flight.
// - Reset clears the counter, the compare registers, the armed, timer
//   pending and software bits, and empties both registers. No clearing
//   pass is needed; requests are taken from the first cycle after reset.
module core_local_timer_interrupter_unit #(
   parameter int NUM_HARTS = clint_pkg::DEFAULT_NUM_HARTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_offset,
   input  logic [3:0]  req_access_size,
   input  logic [63:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [63:0] rsp_read_data,
   output logic [3:0]  rsp_timer_irq,
   output logic [3:0]  rsp_soft_irq
);
   import clint_pkg::*;

   localparam int HART_W = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;

   // Request register
   logic        s1_vld_ff, s1_vld_in;
   logic [1:0]  op_ff;
   logic [15:0] off_ff;
   logic [3:0]  size_ff;
   logic [63:0] wdata_ff;

   // Architectural state
   logic [63:0]          time_ff, time_in;
   logic [63:0]          compare_ff [NUM_HARTS];
   logic [63:0]          compare_in [NUM_HARTS];
   logic [NUM_HARTS-1:0] armed_ff, armed_in;
   logic [NUM_HARTS-1:0] latch_ff, latch_in;
   logic [NUM_HARTS-1:0] soft_ff, soft_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        ok_ff;
   logic [63:0] rdata_ff, rdata_in;
   logic [OUT_HARTS-1:0] tirq_ff, tirq_in;
   logic [OUT_HARTS-1:0] sirq_ff, sirq_in;

   decode_type          dec;
   logic                req_beat;
   logic                adv;
   logic [HART_W-1:0]   hart;

   // Handshake
   assign adv       = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !adv;
   assign req_beat  = req_valid && !req_stall;

   assign s1_vld_in    = req_beat ? 1'b1 : (adv ? 1'b0 : s1_vld_ff);
   assign rsp_valid_in = adv ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   // Decode of the registered request
   clint_decode #(
      .NUM_HARTS (NUM_HARTS)
   ) u_decode (
      .operation   (op_ff),
      .offset      (off_ff),
      .access_size (size_ff),
      .dec         (dec)
   );

   assign hart = dec.hart[HART_W-1:0];

   // Next state and compare evaluation
   always_comb begin
      logic wr_cmp;
      logic arm_mid;
      logic hit;
      time_in = time_ff;
      if (dec.is_tick) begin
         time_in = time_ff + 64'd1;
      end else if (dec.sel_counter && dec.is_write) begin
         time_in = wdata_ff;
      end
      for (int h = 0; h < NUM_HARTS; h++) begin
         wr_cmp        = dec.sel_compare && dec.is_write && (hart == HART_W'(h));
         compare_in[h] = wr_cmp ? wdata_ff : compare_ff[h];
         arm_mid       = armed_ff[h] || wr_cmp || (dec.sel_counter && dec.is_write);
         hit           = arm_mid && (time_in >= compare_in[h]);
         latch_in[h]   = (latch_ff[h] && !wr_cmp) || hit;
         armed_in[h]   = arm_mid && !hit;
         soft_in[h]    = (dec.sel_soft && dec.is_write && (hart == HART_W'(h)))
                         ? wdata_ff[0] : soft_ff[h];
      end
   end

   // Read data
   always_comb begin
      rdata_in = 64'd0;
      if (!dec.is_write) begin
         if (dec.sel_counter) begin
            rdata_in = time_ff;
         end else if (dec.sel_compare) begin
            rdata_in = compare_ff[hart];
         end else if (dec.sel_soft) begin
            rdata_in = {63'd0, soft_ff[hart]};
         end
      end
   end

   // Visible harts; missing ones read as zero
   for (genvar g = 0; g < OUT_HARTS; g++) begin : g_out
      if (g < NUM_HARTS) begin : g_hart
         assign tirq_in[g] = latch_in[g];
         assign sirq_in[g] = soft_in[g];
      end else begin : g_none
         assign tirq_in[g] = 1'b0;
         assign sirq_in[g] = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= 64'd0;
         armed_ff     <= '0;
         latch_ff     <= '0;
         soft_ff      <= '0;
         for (int h = 0; h < NUM_HARTS; h++) begin
            compare_ff[h] <= 64'd0;
         end
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            time_ff  <= time_in;
            armed_ff <= armed_in;
            latch_ff <= latch_in;
            soft_ff  <= soft_in;
            for (int h = 0; h < NUM_HARTS; h++) begin
               compare_ff[h] <= compare_in[h];
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         op_ff    <= req_operation;
         off_ff   <= req_offset;
         size_ff  <= req_access_size;
         wdata_ff <= req_write_data;
      end
      if (adv) begin
         ok_ff    <= dec.ok;
         rdata_ff <= rdata_in;
         tirq_ff  <= tirq_in;
         sirq_ff  <= sirq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_timer_irq = tirq_ff;
   assign rsp_soft_irq  = sirq_ff;

   // Checks
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_vld_ff))
      else $error("response appeared without a registered request");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      (adv && dec.is_tick) |=> (time_ff == $past(time_ff) + 64'd1))
      else $error("tick did not advance the counter by one");

   a_bad_access_idle: assert property (@(posedge clock) disable iff (reset)
      (adv && !dec.ok) |=> (time_ff == $past(time_ff)) && (soft_ff == $past(soft_ff)))
      else $error("rejected access changed state");

endmodule

// ===== rtl/clint_decode.sv =====
// Address and size decoder for the core-local timer interrupter.
// Depends on clint_pkg.
`timescale 1ns / 1ps

module clint_decode #(
   parameter int NUM_HARTS = clint_pkg::DEFAULT_NUM_HARTS
) (
   input  logic [1:0]             operation,
   input  logic [15:0]            offset,
   input  logic [3:0]             access_size,
   output clint_pkg::decode_type  dec
);
   import clint_pkg::*;

   logic        is_bus;
   logic        ctr_hit;
   logic [15:0] cmp_rel;
   logic [12:0] cmp_idx;
   logic        cmp_hit;
   logic [13:0] soft_idx;
   logic        soft_hit;

   // Region hits
   always_comb begin
      is_bus   = (operation == OP_READ) || (operation == OP_WRITE);
      ctr_hit  = (offset == COUNTER_OFFSET) && (access_size == SIZE_DWORD);
      cmp_rel  = offset - COMPARE_BASE;
      cmp_idx  = cmp_rel[15:3];
      cmp_hit  = !ctr_hit && (offset >= COMPARE_BASE) && (access_size == SIZE_DWORD)
                 && (cmp_rel[2:0] == 3'd0) && (cmp_idx < 13'(NUM_HARTS));
      soft_idx = offset[15:2];
      soft_hit = (offset < COMPARE_BASE) && (access_size == SIZE_WORD)
                 && (offset[1:0] == 2'd0) && (soft_idx < 14'(NUM_HARTS));
   end

   // Pack the result
   always_comb begin
      dec.is_tick     = (operation == OP_TICK);
      dec.is_write    = (operation == OP_WRITE);
      dec.sel_counter = is_bus && ctr_hit;
      dec.sel_compare = is_bus && cmp_hit;
      dec.sel_soft    = is_bus && soft_hit;
      dec.ok          = dec.is_tick || dec.sel_counter || dec.sel_compare || dec.sel_soft;
      dec.hart        = cmp_hit ? cmp_idx[HART_IDX_W-1:0] : soft_idx[HART_IDX_W-1:0];
   end

endmodule
